// ===== rtl/fafr_pkg.sv =====
package fafr_pkg;

    localparam int FRAMES   = 64;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VIOLATION = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FREED     = 2'd3;

    localparam logic FUNC_FAULT = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] pid;
        logic [9:0]  vpn;
        logic        write_access;
        logic [10:0] page_count;
        logic [5:0]  release_frame;
    } fafr_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  frame;
        logic        victim_valid;
        logic [15:0] victim_pid;
        logic [9:0]  victim_vpn;
        logic        victim_dirty;
        logic [31:0] arrival_stamp;
        logic [6:0]  free_count;
    } fafr_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DECIDE,
        S_VREAD,
        S_FAULT_WR,
        S_FREE_CHK,
        S_SEARCH,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FREE_WR,
        S_OUT
    } fafr_state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic capture;
        logic init_step;
        logic fault_decide;
        logic victim_read;
        logic fault_write;
        logic search_start;
        logic search_step;
        logic shift_read;
        logic shift_write;
        logic free_write;
        logic set_violation;
        logic set_ignored;
        logic out_load;
    } fafr_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic func_free;
        logic fault_bad;
        logic fault_from_free;
        logic free_ok;
        logic init_done;
        logic search_hit;
        logic search_end;
        logic shift_done;
    } fafr_stat_t;

endpackage

// ===== rtl/fafr_ctrl.sv =====
module fafr_ctrl
    import fafr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  logic       cfg_write,
    input  fafr_stat_t stat,
    output fafr_cmd_t  cmd
);

    fafr_state_t state_reg, state_next;
    logic        mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_INIT;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid = mvalid_reg;
    assign s_ready = (state_reg == S_IDLE) && !cfg_write;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (cfg_write) begin
                    state_next = S_INIT;
                end else if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (stat.init_done) state_next = S_IDLE;
            end
            S_DECIDE: begin
                if (stat.func_free) begin
                    state_next = S_FREE_CHK;
                end else if (stat.fault_bad) begin
                    cmd.set_violation = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.fault_decide = 1'b1;
                    state_next = stat.fault_from_free ? S_FAULT_WR : S_VREAD;
                end
            end
            S_VREAD: begin
                cmd.victim_read = 1'b1;
                state_next = S_FAULT_WR;
            end
            S_FAULT_WR: begin
                cmd.fault_write = 1'b1;
                state_next = S_OUT;
            end
            S_FREE_CHK: begin
                if (stat.free_ok) begin
                    cmd.search_start = 1'b1;
                    state_next = S_SEARCH;
                end else begin
                    cmd.set_ignored = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_SEARCH: begin
                if (stat.search_hit) begin
                    state_next = S_SHIFT_RD;
                end else if (stat.search_end) begin
                    state_next = S_FREE_WR;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            S_SHIFT_RD: begin
                if (stat.shift_done) begin
                    state_next = S_FREE_WR;
                end else begin
                    cmd.shift_read = 1'b1;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_write = 1'b1;
                state_next = S_SHIFT_RD;
            end
            S_FREE_WR: begin
                cmd.free_write = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    mvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/fafr_datapath.sv =====
module fafr_datapath
    import fafr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  fafr_in_t   s_data,
    input  logic       cfg_write,
    input  logic [6:0] cfg_value,
    output logic [6:0] frames_in_use,
    input  fafr_cmd_t  cmd,
    output fafr_stat_t stat,
    output fafr_out_t  m_data
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = IW + 1;

    // memories (each read at one address)
    logic [5:0]  freeq_mem [FRAMES];
    logic [5:0]  loq_mem   [FRAMES];
    logic [15:0] owner_mem [FRAMES];
    logic [9:0]  page_mem  [FRAMES];
    logic [1:0]  flags_mem [FRAMES];

    logic [6:0]    fiu_reg;
    logic [IW-1:0] fhead_reg;
    logic [CW-1:0] fcnt_reg;
    logic [IW-1:0] lhead_reg;
    logic [CW-1:0] lcnt_reg;
    logic [31:0]   arrival_reg;
    logic [CW-1:0] init_reg;
    logic [CW-1:0] idx_reg;
    logic          stat_hit_reg;
    logic          ctl_search_reg;

    fafr_in_t      item_reg;
    fafr_out_t     res_reg, res_next;
    fafr_out_t     out_reg, out_next;
    logic [5:0]    frame_reg;
    logic [5:0]    fq_rd_reg, lq_rd_reg;
    logic [1:0]    fl_rd_reg;
    logic [15:0]   ow_rd_reg;
    logic [9:0]    pg_rd_reg;

    logic [6:0] fiu_clamp;
    always_comb begin
        fiu_clamp = cfg_value;
        if (fiu_clamp == 7'd0) fiu_clamp = 7'd1;
        if ({25'd0, fiu_clamp} > 32'(FRAMES)) fiu_clamp = 7'(FRAMES);
    end

    logic [IW-1:0] fq_addr, lq_addr, rec_addr;
    logic [IW-1:0] lq_pos;
    assign lq_pos = lhead_reg + idx_reg[IW-1:0];

    always_comb begin
        fq_addr  = fhead_reg;
        lq_addr  = lhead_reg;
        rec_addr = IW'(item_reg.release_frame);
        if (cmd.search_step || cmd.shift_read) begin
            lq_addr = (cmd.shift_read) ? lq_pos + IW'(1) : lq_pos + IW'(1);
        end
        if (cmd.search_start) lq_addr = lhead_reg;
        if (cmd.fault_decide) rec_addr = IW'(lq_rd_reg);
        if (cmd.capture) rec_addr = IW'(s_data.release_frame);
    end

    logic victim_now;
    assign victim_now = cmd.fault_decide && (fcnt_reg == '0);

    always_ff @(posedge aclk) begin
        fq_rd_reg <= freeq_mem[fq_addr];
        lq_rd_reg <= loq_mem[lq_addr];
        fl_rd_reg <= flags_mem[rec_addr];
        ow_rd_reg <= owner_mem[rec_addr];
        pg_rd_reg <= page_mem[rec_addr];
        if (cmd.init_step && !init_reg[CW-1 -: 1] && init_reg < CW'(FRAMES)) begin
            freeq_mem[init_reg[IW-1:0]] <= init_reg[5:0];
            flags_mem[init_reg[IW-1:0]] <= 2'b00;
            owner_mem[init_reg[IW-1:0]] <= '0;
            page_mem[init_reg[IW-1:0]]  <= '0;
        end
        if (cmd.fault_write) begin
            owner_mem[IW'(frame_reg)] <= item_reg.pid;
            page_mem[IW'(frame_reg)]  <= item_reg.vpn;
            flags_mem[IW'(frame_reg)] <= {item_reg.write_access, 1'b1};
            loq_mem[lhead_reg + lcnt_reg[IW-1:0]] <= frame_reg;
        end
        if (cmd.shift_write) loq_mem[lq_pos] <= lq_rd_reg;
        if (cmd.free_write) begin
            flags_mem[IW'(item_reg.release_frame)] <= 2'b00;
            owner_mem[IW'(item_reg.release_frame)] <= '0;
            page_mem[IW'(item_reg.release_frame)]  <= '0;
            freeq_mem[fhead_reg + fcnt_reg[IW-1:0]] <= item_reg.release_frame;
        end
    end

    logic found_cur;
    assign found_cur = (lq_rd_reg == item_reg.release_frame);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg      <= 7'(FRAMES);
            fhead_reg    <= '0;
            fcnt_reg     <= CW'(FRAMES);
            lhead_reg    <= '0;
            lcnt_reg     <= '0;
            arrival_reg  <= '0;
            init_reg     <= '0;
            idx_reg      <= '0;
        end else begin
            if (cfg_write) begin
                fiu_reg   <= fiu_clamp;
                fhead_reg <= '0;
                fcnt_reg  <= CW'(fiu_clamp);
                lhead_reg <= '0;
                lcnt_reg  <= '0;
                init_reg  <= '0;
            end
            if (cmd.init_step && init_reg < CW'(FRAMES)) init_reg <= init_reg + CW'(1);
            if (cmd.fault_decide) begin
                if (fcnt_reg != '0) begin
                    fhead_reg <= fhead_reg + IW'(1);
                    fcnt_reg  <= fcnt_reg - CW'(1);
                end else begin
                    lhead_reg <= lhead_reg + IW'(1);
                    lcnt_reg  <= lcnt_reg - CW'(1);
                end
            end
            if (cmd.fault_write) begin
                arrival_reg <= arrival_reg + 32'd1;
                lcnt_reg    <= lcnt_reg + CW'(1);
            end
            if (cmd.search_start) idx_reg <= '0;
            if (cmd.search_step || cmd.shift_write) idx_reg <= idx_reg + CW'(1);
            if (cmd.free_write) begin
                fcnt_reg <= fcnt_reg + CW'(1);
                if (stat_hit_reg) lcnt_reg <= lcnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search_start) stat_hit_reg <= 1'b0;
        else if (found_cur && !stat_hit_reg && idx_reg < lcnt_reg && !cmd.shift_read
                 && !cmd.shift_write && ctl_search_reg)
            stat_hit_reg <= 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) ctl_search_reg <= 1'b0;
        else if (cmd.search_start) ctl_search_reg <= 1'b1;
        else if (cmd.free_write) ctl_search_reg <= 1'b0;
    end

    // datapath results
    always_comb begin
        res_next = res_reg;
        if (cmd.fault_decide) begin
            res_next = '0;
            res_next.victim_valid = victim_now;
        end
        if (cmd.victim_read) begin
            res_next.victim_pid   = ow_rd_reg;
            res_next.victim_vpn   = pg_rd_reg;
            res_next.victim_dirty = fl_rd_reg[1];
        end
        if (cmd.fault_write) begin
            res_next.status        = ST_LOADED;
            res_next.frame         = frame_reg;
            res_next.arrival_stamp = arrival_reg;
        end
        if (cmd.set_violation) begin
            res_next = '0;
            res_next.status = ST_VIOLATION;
        end
        if (cmd.set_ignored) begin
            res_next = '0;
            res_next.status = ST_IGNORED;
            res_next.frame  = item_reg.release_frame;
        end
        if (cmd.free_write) begin
            res_next = '0;
            res_next.status = ST_FREED;
            res_next.frame  = item_reg.release_frame;
        end
    end

    always_comb begin
        out_next = res_reg;
        out_next.free_count = 7'(fcnt_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) item_reg <= s_data;
        if (cmd.fault_decide) frame_reg <= (fcnt_reg != '0) ? fq_rd_reg : lq_rd_reg;
        res_reg <= res_next;
        if (cmd.out_load) out_reg <= out_next;
    end

    assign m_data        = out_reg;
    assign frames_in_use = fiu_reg;

    logic [CW-1:0] init_lim;
    assign init_lim = CW'(FRAMES);

    always_comb begin
        stat = '0;
        stat.func_free       = item_reg.func == FUNC_FREE;
        stat.fault_bad       = ({1'b0, item_reg.vpn} >= item_reg.page_count) ||
                               (fcnt_reg == '0 && lcnt_reg == '0);
        stat.fault_from_free = fcnt_reg != '0;
        stat.free_ok         = ({1'b0, item_reg.release_frame} < fiu_reg) &&
                               (32'(item_reg.release_frame) < 32'(FRAMES)) && fl_rd_reg[0];
        stat.init_done       = init_reg >= init_lim - CW'(1) || init_reg == init_lim;
        stat.search_hit      = stat_hit_reg || (found_cur && idx_reg < lcnt_reg);
        stat.search_end      = idx_reg >= lcnt_reg;
        stat.shift_done      = idx_reg + CW'(1) >= lcnt_reg;
    end

endmodule

// ===== rtl/frame_allocator_fifo_replace.sv =====
// Frame manager with global FIFO replacement, one request at a time. A fault
// passes through accept, decide, record write and output, with a victim
// record read before the record write when it evicts; a page violation goes
// from decide to output, and an ignored free from the free check to output.
// A free walks the load-order queue one entry a cycle and then compacts it
// with a read and a write per entry. The output cycle waits while an earlier
// result is still held. After reset or a frames_in_use write while idle the
// free queue and record memories are swept before the next request is taken.
module frame_allocator_fifo_replace
    import fafr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  fafr_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output fafr_out_t  m_data,
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [0:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    fafr_cmd_t  cmd;
    fafr_stat_t stat;
    logic       cfg_write;
    logic [6:0] fiu;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == 1'b0);
    assign prdata    = {25'd0, fiu};

    fafr_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cfg_write, .stat, .cmd
    );

    fafr_datapath u_dp (
        .aclk, .aresetn, .s_data, .cfg_write, .cfg_value(pwdata[6:0]),
        .frames_in_use(fiu), .cmd, .stat, .m_data
    );

    a_out_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.victim_valid |-> m_data.status == ST_LOADED)
        else $error("victim on non-load result");
    a_free_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {25'd0, m_data.free_count} <= 32'(FRAMES))
        else $error("free count overflow");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.fault_write, cmd.free_write, cmd.shift_write}))
        else $error("conflicting memory writes");

endmodule
